/* hw/rtl/cfr_pkg.sv */
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types, constants and step functions for the conductor Fresnel
// reflectance pipeline.
// ----------------------------------------------------------------------------
package cfr_pkg;

  // Channel count and register port sizing
  localparam int CHANNELS   = 3;
  localparam int IDX_W      = 16;
  localparam int PACK_W     = IDX_W * CHANNELS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = PACK_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_OUTSIDE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ETA_METAL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ABSORB_METAL = 2'd2;

  // Pipeline geometry: two root or quotient bits per stage, one in the last divider stage
  localparam int SQ1_STAGES = 16;   // 32-bit root of a 64-bit word
  localparam int SQ2_STAGES = 13;   // 26-bit root of a 52-bit word
  localparam int DIV_STEPS  = 25;   // Q.24 quotient bits, one to 2^24
  localparam int DIV_STAGES = 13;
  localparam int FRONT_STAGES  = 8;  // input register and front arithmetic
  localparam int MIDDLE_STAGES = 6;  // between the roots and the quotients
  localparam int BACK_STAGES   = 2;  // final product and rounding
  localparam int PIPE_DEPTH = FRONT_STAGES + SQ1_STAGES + SQ2_STAGES
                              + MIDDLE_STAGES + DIV_STAGES + BACK_STAGES;

  // Square root state: remaining radicand bits, partial remainder, root
  typedef struct packed {
    logic [63:0] x;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  // Restoring divider state
  typedef struct packed {
    logic [36:0] rem;
    logic [35:0] den;
    logic [24:0] q;
    logic        zero;
  } dv_t;

  // Side data that travels with the first root
  typedef struct packed {
    logic signed [34:0] t1;
    logic [15:0]        c;
    logic [15:0]        s2h;
    logic [31:0]        ci2;
    logic [31:0]        si2;
  } cr1_t;

  // Side data that travels with the second root
  typedef struct packed {
    logic [15:0] c;
    logic [15:0] s2h;
    logic [34:0] pos_s;
    logic [34:0] pos_p;
  } cr2_t;

  // One digit of the floor square root
  function automatic sq_t sq_step(sq_t s);
    logic [33:0] rem_w;
    logic [33:0] trial;
    sq_t         n;
    rem_w  = {s.rem[31:0], s.x[63:62]};
    trial  = {s.root, 2'b01};
    n.x    = {s.x[61:0], 2'b00};
    if (rem_w >= trial) begin
      n.rem  = rem_w - trial;
      n.root = {s.root[30:0], 1'b1};
    end else begin
      n.rem  = rem_w;
      n.root = {s.root[30:0], 1'b0};
    end
    return n;
  endfunction

  // One quotient bit; the leading bit compares without a shift
  function automatic dv_t dv_step(dv_t d, logic lead);
    logic [36:0] r;
    dv_t         n;
    r = lead ? d.rem : {d.rem[35:0], 1'b0};
    n = d;
    if (r >= {1'b0, d.den}) begin
      n.rem = r - {1'b0, d.den};
      n.q   = {d.q[23:0], 1'b1};
    end else begin
      n.rem = r;
      n.q   = {d.q[23:0], 1'b0};
    end
    return n;
  endfunction

endpackage

/* hw/rtl/cfr_channel.sv */
// ----------------------------------------------------------------------------
// cfr_channel
// One colour channel of the reflectance pipeline: normalised indices, two
// pipelined square roots, two pipelined Q.24 quotients and the final blend.
// ----------------------------------------------------------------------------
module cfr_channel (
  input  logic        clk,
  input  logic        adv,
  input  logic [15:0] eta_out,
  input  logic [15:0] eta_metal,
  input  logic [15:0] absorb,
  input  logic [15:0] cos_raw,
  output logic [15:0] refl
);
  import cfr_pkg::*;

  // --------------------------------------------------------------------------
  // Index constants, refreshed every cycle from the registers
  // --------------------------------------------------------------------------
  logic [15:0] i_eff, m_max, e_sh, k_sh, i_sh;
  logic [3:0]  sh;
  logic [15:0] en_r, kn_r, in_r, ic_r;
  logic [31:0] e2_r, k2_r, i2_r, ek_p;
  logic [30:0] v_r;

  // Scale the triple so that its largest member has bit 15 set
  always_comb begin
    i_eff = (eta_out == 16'd0) ? 16'd1 : eta_out;
    m_max = eta_metal;
    if (absorb > m_max) m_max = absorb;
    if (i_eff > m_max) m_max = i_eff;
    sh = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (m_max[b]) sh = 4'(15 - b);
    end
    e_sh = eta_metal << sh;
    k_sh = absorb << sh;
    i_sh = i_eff << sh;
  end

  function automatic logic [31:0] k2_sq(logic [15:0] k);
    return k * k;
  endfunction

  assign ek_p = en_r * kn_r;

  always_ff @(posedge clk) begin
    en_r <= e_sh;
    kn_r <= k_sh;
    in_r <= i_sh;
    e2_r <= en_r * en_r;
    k2_r <= k2_sq(kn_r);
    i2_r <= in_r * in_r;
    v_r  <= ek_p[31:1];
    ic_r <= in_r;
  end

  // --------------------------------------------------------------------------
  // Front: cosine magnitude, squares and the T1 term
  // --------------------------------------------------------------------------
  logic [15:0] c_nxt, c_1_r, c_2_r, c_3_r;
  logic [31:0] c2_p;
  logic [30:0] c2_1_r, c2_2_r, s2_2_r, s4_3_r;
  logic [62:0] p_si, p_ci, p_si2;
  logic [61:0] p_s4;
  logic [31:0] si_3_r, ci2_3_r;
  logic [15:0] s2h_3_r;
  cr1_t        cr4_nxt, cr4_r, cr5_r, cr6_r, cr7_r;
  logic [34:0] abs_t;
  logic [31:0] u_5_r;
  logic [63:0] uu_6_r, vv_6_r, x_7_r;

  assign c_nxt = cos_raw[15] ? (16'd0 - cos_raw) : cos_raw;
  assign c2_p  = c_nxt * c_nxt;

  assign p_si  = s2_2_r * i2_r;
  assign p_s4  = s2_2_r * s2_2_r;
  assign p_ci  = c2_2_r * i2_r;
  assign p_si2 = s4_3_r * i2_r;

  always_comb begin
    cr4_nxt.t1  = $signed({3'b000, e2_r}) - $signed({3'b000, k2_r})
                  - $signed({3'b000, si_3_r});
    cr4_nxt.c   = c_3_r;
    cr4_nxt.s2h = s2h_3_r;
    cr4_nxt.ci2 = ci2_3_r;
    cr4_nxt.si2 = p_si2[61:30];
  end

  assign abs_t = cr4_r.t1[34] ? 35'(-cr4_r.t1) : 35'(cr4_r.t1);

  always_ff @(posedge clk) begin
    if (adv) begin
      c_1_r   <= c_nxt;
      c2_1_r  <= c2_p[30:0];
      c_2_r   <= c_1_r;
      c2_2_r  <= c2_1_r;
      s2_2_r  <= 31'h4000_0000 - c2_1_r;
      c_3_r   <= c_2_r;
      s2h_3_r <= s2_2_r[30:15];
      si_3_r  <= p_si[61:30];
      s4_3_r  <= p_s4[60:30];
      ci2_3_r <= p_ci[61:30];
      cr4_r   <= cr4_nxt;
      u_5_r   <= abs_t[33:2];
      cr5_r   <= cr4_r;
      uu_6_r  <= u_5_r * u_5_r;
      vv_6_r  <= v_r * v_r;
      cr6_r   <= cr5_r;
      x_7_r   <= uu_6_r + vv_6_r;
      cr7_r   <= cr6_r;
    end
  end

  // --------------------------------------------------------------------------
  // First root: A / 4 = isqrt(u^2 + v^2)
  // --------------------------------------------------------------------------
  sq_t  sq1_r [SQ1_STAGES];
  cr1_t cq1_r [SQ1_STAGES];

  for (genvar j = 0; j < SQ1_STAGES; j++) begin : g_sq1
    sq_t  st_in, st_nxt;
    cr1_t cr_in;
    if (j == 0) begin : g_head
      assign st_in = '{x: x_7_r, rem: '0, root: '0};
      assign cr_in = cr7_r;
    end else begin : g_body
      assign st_in = sq1_r[j-1];
      assign cr_in = cq1_r[j-1];
    end
    assign st_nxt = sq_step(sq_step(st_in));
    always_ff @(posedge clk) begin
      if (adv) begin
        sq1_r[j] <= st_nxt;
        cq1_r[j] <= cr_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // A, the second radicand and the quotient sums that need no root
  // --------------------------------------------------------------------------
  cr1_t               cr_a;
  logic [33:0]        big_a;
  logic signed [35:0] sum_s;
  logic [34:0]        sum_c, pos_s_nxt, pos_p_nxt;
  logic [49:0]        p_bac;
  logic [50:0]        p_ca;
  logic [63:0]        x2_1_r, x2_2_r;
  logic [34:0]        bac_r, pos_s_1_r;
  logic [15:0]        c_p1_r, s2h_p1_r;
  logic [31:0]        si2_p1_r;
  cr2_t               cr2_nxt, cr2_r;

  assign cr_a      = cq1_r[SQ1_STAGES-1];
  assign big_a     = {sq1_r[SQ1_STAGES-1].root, 2'b00};
  assign sum_s     = $signed({2'b00, big_a}) + $signed({cr_a.t1[34], cr_a.t1});
  assign sum_c     = sum_s[35] ? 35'd0 : sum_s[34:0];
  assign p_bac     = big_a * cr_a.c;
  assign pos_s_nxt = big_a + cr_a.ci2;
  assign p_ca      = bac_r * c_p1_r;
  assign pos_p_nxt = p_ca[48:15] + si2_p1_r;

  always_comb begin
    cr2_nxt.c     = c_p1_r;
    cr2_nxt.s2h   = s2h_p1_r;
    cr2_nxt.pos_s = pos_s_1_r;
    cr2_nxt.pos_p = pos_p_nxt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // radicand (A + T1) << 15, left aligned on a 52-bit word
      x2_1_r    <= {2'b00, sum_c, 27'd0};
      bac_r     <= p_bac[49:15];
      pos_s_1_r <= pos_s_nxt;
      c_p1_r    <= cr_a.c;
      s2h_p1_r  <= cr_a.s2h;
      si2_p1_r  <= cr_a.si2;
      x2_2_r    <= x2_1_r;
      cr2_r     <= cr2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Second root: a in units of 2^-8
  // --------------------------------------------------------------------------
  sq_t  sq2_r [SQ2_STAGES];
  cr2_t cq2_r [SQ2_STAGES];

  for (genvar j = 0; j < SQ2_STAGES; j++) begin : g_sq2
    sq_t  st_in, st_nxt;
    cr2_t cr_in;
    if (j == 0) begin : g_head
      assign st_in = '{x: x2_2_r, rem: '0, root: '0};
      assign cr_in = cr2_r;
    end else begin : g_body
      assign st_in = sq2_r[j-1];
      assign cr_in = cq2_r[j-1];
    end
    assign st_nxt = sq_step(sq_step(st_in));
    always_ff @(posedge clk) begin
      if (adv) begin
        sq2_r[j] <= st_nxt;
        cq2_r[j] <= cr_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cross terms and the two quotient operand pairs
  // --------------------------------------------------------------------------
  logic [24:0] a8;
  logic [40:0] ai_r;
  cr2_t        cr_q1_r, cr_q2_r;
  logic [56:0] p_tac;
  logic [33:0] tac_r, tsc_r;
  logic [49:0] p_tsc;
  logic [34:0] num_s_nxt, nums_r, posp_r, num_p_nxt;
  logic [35:0] dens_r;
  dv_t         dvs_init_r, dvp_init_r;

  assign a8    = sq2_r[SQ2_STAGES-1].root[24:0];
  assign p_tac = ai_r * cr_q1_r.c;
  assign p_tsc = tac_r * cr_q2_r.s2h;

  // Floor each numerator at zero
  assign num_s_nxt = (cr_q2_r.pos_s >= {1'b0, tac_r}) ? cr_q2_r.pos_s - tac_r : 35'd0;
  assign num_p_nxt = (posp_r >= {1'b0, tsc_r}) ? posp_r - tsc_r : 35'd0;

  always_ff @(posedge clk) begin
    if (adv) begin
      ai_r    <= a8 * ic_r;
      cr_q1_r <= cq2_r[SQ2_STAGES-1];
      tac_r   <= p_tac[55:22];
      cr_q2_r <= cr_q1_r;
      tsc_r   <= p_tsc[48:15];
      nums_r  <= num_s_nxt;
      dens_r  <= cr_q2_r.pos_s + tac_r;
      posp_r  <= cr_q2_r.pos_p;
      dvs_init_r <= '{rem: {2'b00, nums_r}, den: dens_r, q: '0,
                      zero: (dens_r == 36'd0)};
      dvp_init_r <= '{rem: {2'b00, num_p_nxt}, den: posp_r + tsc_r, q: '0,
                      zero: ((posp_r + tsc_r) == 36'd0)};
    end
  end

  // --------------------------------------------------------------------------
  // Rs and the Rp ratio, two quotient bits per stage each, one in the last stage
  // --------------------------------------------------------------------------
  dv_t dvs_r [DIV_STAGES];
  dv_t dvp_r [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    dv_t ds_in, dp_in, ds_nxt, dp_nxt;
    if (j == 0) begin : g_head
      assign ds_in = dvs_init_r;
      assign dp_in = dvp_init_r;
    end else begin : g_body
      assign ds_in = dvs_r[j-1];
      assign dp_in = dvp_r[j-1];
    end
    always_comb begin
      ds_nxt = ds_in;
      dp_nxt = dp_in;
      for (int s = 0; s < 2; s++) begin
        if (2 * j + s < DIV_STEPS) begin
          ds_nxt = dv_step(ds_nxt, (2 * j + s) == 0);
          dp_nxt = dv_step(dp_nxt, (2 * j + s) == 0);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dvs_r[j] <= ds_nxt;
        dvp_r[j] <= dp_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Rp = Rs * ratio, then R = (Rs + Rp) / 2 in Q1.15 with saturation
  // --------------------------------------------------------------------------
  logic [24:0] rs, ratio, rs_m_r, rp_m_r;
  logic [49:0] p_rp;
  logic [25:0] r_sum;
  logic [15:0] r_sh, refl_r;

  // A zero denominator reads as one
  assign rs    = dvs_r[DIV_STAGES-1].zero ? 25'h100_0000 : dvs_r[DIV_STAGES-1].q;
  assign ratio = dvp_r[DIV_STAGES-1].zero ? 25'h100_0000 : dvp_r[DIV_STAGES-1].q;
  assign p_rp  = rs * ratio;
  assign r_sum = rs_m_r + rp_m_r + 26'd512;
  assign r_sh  = r_sum[25:10];

  always_ff @(posedge clk) begin
    if (adv) begin
      rs_m_r <= rs;
      rp_m_r <= p_rp[48:24];
      refl_r <= (r_sh > 16'd32768) ? 16'd32768 : r_sh;
    end
  end

  assign refl = refl_r;

endmodule

/* hw/rtl/conductor_fresnel_reflectance.sv */
// ----------------------------------------------------------------------------
// conductor_fresnel_reflectance
// Unpolarised Fresnel reflectance of a conductor for red, green and blue,
// one incident cosine in, one reflectance triple out.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  in       | in_valid/in_ready  | in_cos_incident (Q1.15 signed)
//  out      | out_valid/out_ready| out_refl_red/green/blue (Q1.15)
//  cfg      | cfg_we             | cfg_index, cfg_wdata
//
//  One beat per cycle sustained while out_ready holds; the pipeline is PIPE_DEPTH
//  registers deep, most in the two pipelined square roots and the Q.24 quotients.
//  The whole pipeline advances together; a stall at the output holds every
//  stage, and in_ready follows out_ready while the output register is full.
//  Reset clears the valid bits and loads the registers (outside index 1.0).
// ----------------------------------------------------------------------------
module conductor_fresnel_reflectance (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [15:0]               in_cos_incident,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [15:0]                      out_refl_red,
  output logic [15:0]                      out_refl_green,
  output logic [15:0]                      out_refl_blue,
  input  logic                             cfg_we,
  input  logic [cfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import cfr_pkg::*;

  logic [IDX_W-1:0]      eta_outside_r;
  logic [PACK_W-1:0]     eta_metal_r;
  logic [PACK_W-1:0]     absorb_metal_r;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [15:0]           cos_s0_r;
  logic                  adv;
  logic [15:0]           refl_w [CHANNELS];

  // Register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_outside_r  <= 16'd4096;
      eta_metal_r    <= '0;
      absorb_metal_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ETA_OUTSIDE:  eta_outside_r  <= cfg_wdata[IDX_W-1:0];
        CFG_ETA_METAL:    eta_metal_r    <= cfg_wdata[PACK_W-1:0];
        CFG_ABSORB_METAL: absorb_metal_r <= cfg_wdata[PACK_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance whenever the output register is empty or being drained
  assign adv      = out_ready || !vld_r[PIPE_DEPTH-1];
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos_s0_r <= in_cos_incident;
    end
  end

  // One datapath per colour
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
    cfr_channel u_channel (
      .clk       (clk),
      .adv       (adv),
      .eta_out   (eta_outside_r),
      .eta_metal (eta_metal_r[IDX_W*ch +: IDX_W]),
      .absorb    (absorb_metal_r[IDX_W*ch +: IDX_W]),
      .cos_raw   (cos_s0_r),
      .refl      (refl_w[ch])
    );
  end

  assign out_valid      = vld_r[PIPE_DEPTH-1];
  assign out_refl_red   = refl_w[0];
  assign out_refl_green = refl_w[1];
  assign out_refl_blue  = refl_w[2];

  // Checks
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_refl_red <= 16'd32768 && out_refl_green <= 16'd32768 &&
                   out_refl_blue <= 16'd32768))
    else $error("reflectance beyond one");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(vld_r))
    else $error("pipeline moved during a stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted beat not captured");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
